// File: hw/rtl/aldp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aldp_pkg;

    localparam int CZ_W       = 10;
    localparam int CX_W       = 10;
    localparam int VEL_W      = 16;
    localparam int DAMP_W     = 32;
    localparam int PAD_W      = 8;
    localparam int SP_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int RATIO_BITS = 24;

    localparam int PROD_W  = PAD_W + SP_W;       // distance times spacing
    localparam int SQ_W    = 2 * PROD_W;         // squared term
    localparam int SUM_W   = SQ_W + 1;           // sum of two squares
    localparam int GV_W    = GAIN_W + VEL_W;     // gain times velocity
    localparam int WID_IW  = SUM_W + 9;          // den * 256, padded to even width
    localparam int WID_W   = WID_IW / 2;         // layer width in 1/256 m
    localparam int BNUM_W  = GV_W + 8;           // dividend of the base coefficient
    localparam int BASE_W  = 44;                 // base coefficient, Q28.16
    localparam int F_W     = RATIO_BITS + 1;     // profile factor, Q1.24
    localparam int Y_W     = 32;                 // exponential accumulator, Q2.30
    localparam int BH_W    = BASE_W - 22;        // upper slice of base
    localparam int BL_W    = 22;                 // lower slice of base
    localparam int FH_W    = F_W - 12;           // upper slice of factor
    localparam int FL_W    = 12;                 // lower slice of factor
    localparam int HI_W    = BASE_W + FH_W;      // base times upper factor
    localparam int LO_W    = BASE_W + FL_W;      // base times lower factor
    localparam int D_W     = HI_W - 12;          // unclipped damping

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROFILE_MODE = 3'd0,
        CFG_REFL_GAIN    = 3'd1,
        CFG_SPACING_Z    = 3'd2,
        CFG_SPACING_X    = 3'd3,
        CFG_PAD_TOP      = 3'd4,
        CFG_PAD_BOTTOM   = 3'd5,
        CFG_PAD_LEFT     = 3'd6,
        CFG_PAD_RIGHT    = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        MODE_QUADRATIC   = 1'b0,
        MODE_EXPONENTIAL = 1'b1
    } profile_mode_t;

    typedef struct packed {
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] den;
        logic [GV_W-1:0]  gv;
        logic             in_layer;
    } wid_sb_t;

    typedef struct packed {
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] den;
        logic             in_layer;
    } base_sb_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              q0;
        logic              in_layer;
    } ratio_sb_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [F_W-1:0]    r2;
        logic              in_layer;
    } exp_sb_t;

endpackage

`default_nettype wire

// File: hw/rtl/aldp_grid_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aldp_grid_if;
    logic                        valid;
    logic                        ready;
    logic [aldp_pkg::CZ_W-1:0]   cell_z;
    logic [aldp_pkg::CX_W-1:0]   cell_x;
    logic [aldp_pkg::VEL_W-1:0]  velocity;

    modport source (output valid, output cell_z, output cell_x, output velocity, input ready);
    modport sink   (input valid, input cell_z, input cell_x, input velocity, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/aldp_coef_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aldp_coef_if;
    logic                         valid;
    logic                         ready;
    logic [aldp_pkg::DAMP_W-1:0]  damping;
    logic                         in_layer;
    logic                         saturated;

    modport source (output valid, output damping, output in_layer, output saturated, input ready);
    modport sink   (input valid, input damping, input in_layer, input saturated, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/aldp_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// floor square root, one result bit per stage
module aldp_sqrt_pipe #(
    parameter int IW  = 64,
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IW-1:0]     in_val,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [IW/2-1:0]   out_root,
    output logic [SBW-1:0]    out_sb
);

    localparam int NS = IW / 2;
    localparam int RW = NS + 1;

    logic             vld_reg  [NS];
    logic [RW-1:0]    rem_reg  [NS];
    logic [NS-1:0]    root_reg [NS];
    logic [IW-1:0]    v_reg    [NS];
    logic [SBW-1:0]   sb_reg   [NS];

    generate
        for (genvar k = 0; k < NS; k++)
        begin : g_st
            logic           vld_p;
            logic [RW-1:0]  rem_p;
            logic [NS-1:0]  root_p;
            logic [IW-1:0]  v_p;
            logic [SBW-1:0] sb_p;
            logic [RW+1:0]  remx;
            logic [RW+1:0]  trial;
            logic           ge;
            logic [RW-1:0]  rem_next;
            logic [NS-1:0]  root_next;

            if (k == 0)
            begin : g_first
                assign vld_p  = in_valid;
                assign rem_p  = '0;
                assign root_p = '0;
                assign v_p    = in_val;
                assign sb_p   = in_sb;
            end
            else
            begin : g_rest
                assign vld_p  = vld_reg[k-1];
                assign rem_p  = rem_reg[k-1];
                assign root_p = root_reg[k-1];
                assign v_p    = v_reg[k-1];
                assign sb_p   = sb_reg[k-1];
            end

            assign remx      = {rem_p, v_p[IW-1 -: 2]};
            assign trial     = {1'b0, root_p, 2'b01};
            assign ge        = (remx >= trial);
            assign rem_next  = ge ? RW'(remx - trial) : RW'(remx);
            assign root_next = {root_p[NS-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_p;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    v_reg[k]    <= {v_p[IW-3:0], 2'b00};
                    sb_reg[k]   <= sb_p;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_sb    = sb_reg[NS-1];

endmodule

`default_nettype wire

// File: hw/rtl/aldp_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring long division, one quotient bit per stage, starts from a partial remainder
module aldp_div_pipe #(
    parameter int DW  = 32,
    parameter int QW  = 32,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [DW-1:0]   in_rem,
    input  logic [QW-1:0]   in_num,
    input  logic [DW-1:0]   in_den,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [QW-1:0]   out_q,
    output logic [SBW-1:0]  out_sb
);

    logic             vld_reg [QW];
    logic [DW-1:0]    rem_reg [QW];
    logic [QW-1:0]    num_reg [QW];
    logic [DW-1:0]    den_reg [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [SBW-1:0]   sb_reg  [QW];

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_st
            logic           vld_p;
            logic [DW-1:0]  rem_p;
            logic [QW-1:0]  num_p;
            logic [DW-1:0]  den_p;
            logic [QW-1:0]  q_p;
            logic [SBW-1:0] sb_p;
            logic [DW:0]    rx;
            logic           ge;
            logic [DW-1:0]  rem_next;

            if (k == 0)
            begin : g_first
                assign vld_p = in_valid;
                assign rem_p = in_rem;
                assign num_p = in_num;
                assign den_p = in_den;
                assign q_p   = '0;
                assign sb_p  = in_sb;
            end
            else
            begin : g_rest
                assign vld_p = vld_reg[k-1];
                assign rem_p = rem_reg[k-1];
                assign num_p = num_reg[k-1];
                assign den_p = den_reg[k-1];
                assign q_p   = q_reg[k-1];
                assign sb_p  = sb_reg[k-1];
            end

            assign rx       = {rem_p, num_p[QW-1]};
            assign ge       = (rx >= {1'b0, den_p});
            assign rem_next = ge ? DW'(rx - {1'b0, den_p}) : DW'(rx);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_p;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    num_reg[k] <= {num_p[QW-2:0], 1'b0};
                    den_reg[k] <= den_p;
                    q_reg[k]   <= {q_p[QW-2:0], ge};
                    sb_reg[k]  <= sb_p;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule

`default_nettype wire

// File: hw/rtl/aldp_exp_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// 2^r by repeated square roots: y = sqrt(y or 2y), lowest ratio bit first
module aldp_exp_chain #(
    parameter int SBW = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [aldp_pkg::RATIO_BITS-1:0] in_bits,
    input  logic [SBW-1:0]                  in_sb,
    output logic                            out_valid,
    output logic [aldp_pkg::Y_W-1:0]        out_y,
    output logic [SBW-1:0]                  out_sb
);

    localparam int NB  = aldp_pkg::RATIO_BITS;
    localparam int YW  = aldp_pkg::Y_W;
    localparam int IW  = 2 * YW;
    localparam int CSB = NB + SBW;

    logic            vld_w  [NB+1];
    logic [YW-1:0]   y_w    [NB+1];
    logic [NB-1:0]   bits_w [NB+1];
    logic [SBW-1:0]  sb_w   [NB+1];

    assign vld_w[0]  = in_valid;
    assign y_w[0]    = YW'(1) << (YW - 2);
    assign bits_w[0] = in_bits;
    assign sb_w[0]   = in_sb;

    generate
        for (genvar i = 0; i < NB; i++)
        begin : g_step
            logic [YW:0]     t;
            logic [IW-1:0]   sq_in;
            logic [CSB-1:0]  csb_in;
            logic [CSB-1:0]  csb_out;

            // radicand is t * 2^30, both sides Q2.30
            assign t      = bits_w[i][i] ? {y_w[i], 1'b0} : {1'b0, y_w[i]};
            assign sq_in  = {1'b0, t, {(IW-YW-2){1'b0}}};
            assign csb_in = {bits_w[i], sb_w[i]};

            aldp_sqrt_pipe #(
                .IW  (IW),
                .SBW (CSB)
            ) u_sqrt (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (vld_w[i]),
                .in_val    (sq_in),
                .in_sb     (csb_in),
                .out_valid (vld_w[i+1]),
                .out_root  (y_w[i+1]),
                .out_sb    (csb_out)
            );

            assign bits_w[i+1] = csb_out[CSB-1 -: NB];
            assign sb_w[i+1]   = csb_out[SBW-1:0];
        end
    endgenerate

    assign out_valid = vld_w[NB];
    assign out_y     = y_w[NB];
    assign out_sb    = sb_w[NB];

endmodule

`default_nettype wire

// File: hw/rtl/absorbing_layer_damping_profile_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  beat
// grid     in   cell_z[9:0], cell_x[9:0], velocity[15:0]
// coef     out  damping[31:0], in_layer, saturated
// cfg      in   cfg_we, cfg_index[2:0], cfg_data[23:0], no read-back
//
// one beat per cycle in, one per cycle out while coef takes them; the depth of the pipeline
// is set mostly by the 24 chained 32-stage square roots of the exponential profile
// all stages advance together, so a stall at coef holds the whole pipeline
// reset clears valid bits and config registers; spacings come up as 16, the rest 0

module absorbing_layer_damping_profile_top #(
    parameter int GRID_DEPTH = 1024,
    parameter int GRID_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aldp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aldp_pkg::CFG_W-1:0]     cfg_data,
    aldp_grid_if.sink                      grid,
    aldp_coef_if.source                    coef
);

    localparam int N_W   = 17;
    localparam int PAD_W = aldp_pkg::PAD_W;
    localparam int SP_W  = aldp_pkg::SP_W;
    localparam logic [N_W-1:0] DEPTH_N = N_W'(GRID_DEPTH);
    localparam logic [N_W-1:0] WIDTH_N = N_W'(GRID_WIDTH);
    localparam int PHH_W = aldp_pkg::BH_W + aldp_pkg::FH_W;
    localparam int PHL_W = aldp_pkg::BL_W + aldp_pkg::FH_W;
    localparam int PLH_W = aldp_pkg::BH_W + aldp_pkg::FL_W;
    localparam int PLL_W = aldp_pkg::BL_W + aldp_pkg::FL_W;

    typedef struct packed {
        logic             hit;
        logic [PAD_W-1:0] depth;
        logic [PAD_W-1:0] thick;
    } loc_t;

    function automatic loc_t locate(input logic [aldp_pkg::CZ_W-1:0] c,
                                    input logic [N_W-1:0] n,
                                    input logic [PAD_W-1:0] lo,
                                    input logic [PAD_W-1:0] hi);
        loc_t            r;
        logic [N_W-1:0]  cw;
        logic [N_W-1:0]  low;
        logic [N_W-1:0]  hiw;
        r   = '0;
        cw  = N_W'(c);
        low = N_W'(lo);
        hiw = N_W'(hi);
        if (cw < n)
        begin
            if (cw < low)
            begin
                r.hit   = 1'b1;
                r.depth = PAD_W'(low - cw);
                r.thick = lo;
            end
            else if (cw + hiw >= n)
            begin
                r.hit   = 1'b1;
                r.depth = PAD_W'(cw + N_W'(1) + hiw - n);
                r.thick = hi;
            end
        end
        return r;
    endfunction

    // configuration registers
    logic                          mode_reg;
    logic [aldp_pkg::GAIN_W-1:0]   gain_reg;
    logic [SP_W-1:0]               spz_reg;
    logic [SP_W-1:0]               spx_reg;
    logic [PAD_W-1:0]              pad_top_reg;
    logic [PAD_W-1:0]              pad_bottom_reg;
    logic [PAD_W-1:0]              pad_left_reg;
    logic [PAD_W-1:0]              pad_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= aldp_pkg::MODE_QUADRATIC;
            gain_reg       <= '0;
            spz_reg        <= SP_W'(16);
            spx_reg        <= SP_W'(16);
            pad_top_reg    <= '0;
            pad_bottom_reg <= '0;
            pad_left_reg   <= '0;
            pad_right_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (aldp_pkg::cfg_idx_t'(cfg_index))
                aldp_pkg::CFG_PROFILE_MODE: mode_reg       <= cfg_data[0];
                aldp_pkg::CFG_REFL_GAIN:    gain_reg       <= cfg_data;
                aldp_pkg::CFG_SPACING_Z:    spz_reg        <= cfg_data[SP_W-1:0];
                aldp_pkg::CFG_SPACING_X:    spx_reg        <= cfg_data[SP_W-1:0];
                aldp_pkg::CFG_PAD_TOP:      pad_top_reg    <= cfg_data[PAD_W-1:0];
                aldp_pkg::CFG_PAD_BOTTOM:   pad_bottom_reg <= cfg_data[PAD_W-1:0];
                aldp_pkg::CFG_PAD_LEFT:     pad_left_reg   <= cfg_data[PAD_W-1:0];
                aldp_pkg::CFG_PAD_RIGHT:    pad_right_reg  <= cfg_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SP_W-1:0] sz;
    logic [SP_W-1:0] sx;
    assign sz = (spz_reg == '0) ? SP_W'(1) : spz_reg;
    assign sx = (spx_reg == '0) ? SP_W'(1) : spx_reg;

    logic en;
    logic out_vld_reg;
    assign en         = !out_vld_reg || coef.ready;
    assign grid.ready = en;

    // stage 1: pad location
    loc_t loc_z;
    loc_t loc_x;
    logic in_grid;
    assign loc_z   = locate(grid.cell_z, DEPTH_N, pad_top_reg, pad_bottom_reg);
    assign loc_x   = locate(grid.cell_x, WIDTH_N, pad_left_reg, pad_right_reg);
    assign in_grid = (N_W'(grid.cell_z) < DEPTH_N) && (N_W'(grid.cell_x) < WIDTH_N);

    logic                         s1_vld_reg;
    logic [PAD_W-1:0]             s1_dz_reg;
    logic [PAD_W-1:0]             s1_tz_reg;
    logic [PAD_W-1:0]             s1_dx_reg;
    logic [PAD_W-1:0]             s1_tx_reg;
    logic [aldp_pkg::VEL_W-1:0]   s1_vel_reg;
    logic                         s1_il_reg;

    // stage 2: scale by spacing, gain times velocity
    logic                         s2_vld_reg;
    logic [aldp_pkg::PROD_W-1:0]  s2_pdz_reg;
    logic [aldp_pkg::PROD_W-1:0]  s2_ptz_reg;
    logic [aldp_pkg::PROD_W-1:0]  s2_pdx_reg;
    logic [aldp_pkg::PROD_W-1:0]  s2_ptx_reg;
    logic [aldp_pkg::GV_W-1:0]    s2_gv_reg;
    logic                         s2_il_reg;

    // stage 3: squares
    logic                         s3_vld_reg;
    logic [aldp_pkg::SQ_W-1:0]    s3_qdz_reg;
    logic [aldp_pkg::SQ_W-1:0]    s3_qtz_reg;
    logic [aldp_pkg::SQ_W-1:0]    s3_qdx_reg;
    logic [aldp_pkg::SQ_W-1:0]    s3_qtx_reg;
    logic [aldp_pkg::GV_W-1:0]    s3_gv_reg;
    logic                         s3_il_reg;

    // stage 4: sums
    logic                         s4_vld_reg;
    logic [aldp_pkg::SUM_W-1:0]   s4_num_reg;
    logic [aldp_pkg::SUM_W-1:0]   s4_den_reg;
    logic [aldp_pkg::GV_W-1:0]    s4_gv_reg;
    logic                         s4_il_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= grid.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dz_reg  <= loc_z.depth;
            s1_tz_reg  <= loc_z.thick;
            s1_dx_reg  <= loc_x.depth;
            s1_tx_reg  <= loc_x.thick;
            s1_vel_reg <= grid.velocity;
            s1_il_reg  <= in_grid && (loc_z.hit || loc_x.hit);

            s2_pdz_reg <= aldp_pkg::PROD_W'(s1_dz_reg) * aldp_pkg::PROD_W'(sz);
            s2_ptz_reg <= aldp_pkg::PROD_W'(s1_tz_reg) * aldp_pkg::PROD_W'(sz);
            s2_pdx_reg <= aldp_pkg::PROD_W'(s1_dx_reg) * aldp_pkg::PROD_W'(sx);
            s2_ptx_reg <= aldp_pkg::PROD_W'(s1_tx_reg) * aldp_pkg::PROD_W'(sx);
            s2_gv_reg  <= aldp_pkg::GV_W'(gain_reg) * aldp_pkg::GV_W'(s1_vel_reg);
            s2_il_reg  <= s1_il_reg;

            s3_qdz_reg <= aldp_pkg::SQ_W'(s2_pdz_reg) * aldp_pkg::SQ_W'(s2_pdz_reg);
            s3_qtz_reg <= aldp_pkg::SQ_W'(s2_ptz_reg) * aldp_pkg::SQ_W'(s2_ptz_reg);
            s3_qdx_reg <= aldp_pkg::SQ_W'(s2_pdx_reg) * aldp_pkg::SQ_W'(s2_pdx_reg);
            s3_qtx_reg <= aldp_pkg::SQ_W'(s2_ptx_reg) * aldp_pkg::SQ_W'(s2_ptx_reg);
            s3_gv_reg  <= s2_gv_reg;
            s3_il_reg  <= s2_il_reg;

            s4_num_reg <= aldp_pkg::SUM_W'(s3_qdz_reg) + aldp_pkg::SUM_W'(s3_qdx_reg);
            s4_den_reg <= aldp_pkg::SUM_W'(s3_qtz_reg) + aldp_pkg::SUM_W'(s3_qtx_reg);
            s4_gv_reg  <= s3_gv_reg;
            s4_il_reg  <= s3_il_reg;
        end
    end

    // layer width W = isqrt(den * 256)
    aldp_pkg::wid_sb_t              wid_sb_in;
    aldp_pkg::wid_sb_t              wid_sb_out;
    logic                           wid_vld;
    logic [aldp_pkg::WID_W-1:0]     wid_root;

    assign wid_sb_in = '{num: s4_num_reg, den: s4_den_reg, gv: s4_gv_reg,
                         in_layer: s4_il_reg};

    aldp_sqrt_pipe #(
        .IW  (aldp_pkg::WID_IW),
        .SBW ($bits(aldp_pkg::wid_sb_t))
    ) u_width (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_vld_reg),
        .in_val    ({1'b0, s4_den_reg, 8'b0}),
        .in_sb     (wid_sb_in),
        .out_valid (wid_vld),
        .out_root  (wid_root),
        .out_sb    (wid_sb_out)
    );

    // base = gain * velocity * 256 / W
    aldp_pkg::base_sb_t             base_sb_in;
    aldp_pkg::base_sb_t             base_sb_out;
    logic                           base_vld;
    logic [aldp_pkg::BNUM_W-1:0]    base_q;

    assign base_sb_in = '{num: wid_sb_out.num, den: wid_sb_out.den,
                          in_layer: wid_sb_out.in_layer};

    aldp_div_pipe #(
        .DW  (aldp_pkg::WID_W),
        .QW  (aldp_pkg::BNUM_W),
        .SBW ($bits(aldp_pkg::base_sb_t))
    ) u_base_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wid_vld),
        .in_rem    ('0),
        .in_num    ({wid_sb_out.gv, 8'b0}),
        .in_den    (wid_root),
        .in_sb     (base_sb_in),
        .out_valid (base_vld),
        .out_q     (base_q),
        .out_sb    (base_sb_out)
    );

    // integer part of num/den, which is 0 or 1 since num <= den
    logic                           s5_vld_reg;
    logic                           s5_q0_reg;
    logic [aldp_pkg::SUM_W-1:0]     s5_rem_reg;
    logic [aldp_pkg::SUM_W-1:0]     s5_den_reg;
    logic [aldp_pkg::BASE_W-1:0]    s5_base_reg;
    logic                           s5_il_reg;
    logic                           q0;

    assign q0 = (base_sb_out.num >= base_sb_out.den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= base_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_q0_reg   <= q0;
            s5_rem_reg  <= q0 ? base_sb_out.num - base_sb_out.den : base_sb_out.num;
            s5_den_reg  <= base_sb_out.den;
            s5_base_reg <= base_q[aldp_pkg::BASE_W-1:0];
            s5_il_reg   <= base_sb_out.in_layer;
        end
    end

    // fractional bits of r^2
    aldp_pkg::ratio_sb_t                ratio_sb_in;
    aldp_pkg::ratio_sb_t                ratio_sb_out;
    logic                               ratio_vld;
    logic [aldp_pkg::RATIO_BITS-1:0]    ratio_q;

    assign ratio_sb_in = '{base: s5_base_reg, q0: s5_q0_reg, in_layer: s5_il_reg};

    aldp_div_pipe #(
        .DW  (aldp_pkg::SUM_W),
        .QW  (aldp_pkg::RATIO_BITS),
        .SBW ($bits(aldp_pkg::ratio_sb_t))
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .in_rem    (s5_rem_reg),
        .in_num    ('0),
        .in_den    (s5_den_reg),
        .in_sb     (ratio_sb_in),
        .out_valid (ratio_vld),
        .out_q     (ratio_q),
        .out_sb    (ratio_sb_out)
    );

    // exponential profile
    aldp_pkg::exp_sb_t              exp_sb_in;
    aldp_pkg::exp_sb_t              exp_sb_out;
    logic                           exp_vld;
    logic [aldp_pkg::Y_W-1:0]       exp_y;

    assign exp_sb_in = '{base: ratio_sb_out.base, r2: {ratio_sb_out.q0, ratio_q},
                         in_layer: ratio_sb_out.in_layer};

    aldp_exp_chain #(
        .SBW ($bits(aldp_pkg::exp_sb_t))
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ratio_vld),
        .in_bits   (ratio_q),
        .in_sb     (exp_sb_in),
        .out_valid (exp_vld),
        .out_y     (exp_y),
        .out_sb    (exp_sb_out)
    );

    // profile factor
    logic [aldp_pkg::F_W-1:0] f_next;
    always_comb
    begin
        if (mode_reg == aldp_pkg::MODE_QUADRATIC)
            f_next = exp_sb_out.r2;
        else if (exp_sb_out.r2[aldp_pkg::RATIO_BITS])
            f_next = aldp_pkg::F_W'(1) << aldp_pkg::RATIO_BITS;
        else
            f_next = aldp_pkg::F_W'(exp_y >> 6) - (aldp_pkg::F_W'(1) << aldp_pkg::RATIO_BITS);
    end

    logic                           m0_vld_reg;
    logic [aldp_pkg::F_W-1:0]       m0_f_reg;
    logic [aldp_pkg::BASE_W-1:0]    m0_base_reg;
    logic                           m0_il_reg;

    // base * f in four partial products
    logic                           m1_vld_reg;
    logic [PHH_W-1:0]               m1_phh_reg;
    logic [PHL_W-1:0]               m1_phl_reg;
    logic [PLH_W-1:0]               m1_plh_reg;
    logic [PLL_W-1:0]               m1_pll_reg;
    logic                           m1_il_reg;

    logic                           m2_vld_reg;
    logic [aldp_pkg::HI_W-1:0]      m2_hi_reg;
    logic [aldp_pkg::LO_W-1:0]      m2_lo_reg;
    logic                           m2_il_reg;

    logic [aldp_pkg::BH_W-1:0]      b_hi;
    logic [aldp_pkg::BL_W-1:0]      b_lo;
    logic [aldp_pkg::FH_W-1:0]      f_hi;
    logic [aldp_pkg::FL_W-1:0]      f_lo;

    assign b_hi = m0_base_reg[aldp_pkg::BASE_W-1 -: aldp_pkg::BH_W];
    assign b_lo = m0_base_reg[aldp_pkg::BL_W-1:0];
    assign f_hi = m0_f_reg[aldp_pkg::F_W-1 -: aldp_pkg::FH_W];
    assign f_lo = m0_f_reg[aldp_pkg::FL_W-1:0];

    logic [aldp_pkg::HI_W-1:0]      sum_next;
    logic [aldp_pkg::D_W-1:0]       d_next;
    logic                           sat_next;

    assign sum_next = m2_hi_reg + aldp_pkg::HI_W'(m2_lo_reg >> 12);
    assign d_next   = sum_next[aldp_pkg::HI_W-1:12];
    assign sat_next = |d_next[aldp_pkg::D_W-1:aldp_pkg::DAMP_W];

    logic [aldp_pkg::DAMP_W-1:0]    out_damp_reg;
    logic                           out_il_reg;
    logic                           out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m0_vld_reg  <= exp_vld;
            m1_vld_reg  <= m0_vld_reg;
            m2_vld_reg  <= m1_vld_reg;
            out_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_f_reg    <= f_next;
            m0_base_reg <= exp_sb_out.base;
            m0_il_reg   <= exp_sb_out.in_layer;

            m1_phh_reg  <= PHH_W'(b_hi) * PHH_W'(f_hi);
            m1_phl_reg  <= PHL_W'(b_lo) * PHL_W'(f_hi);
            m1_plh_reg  <= PLH_W'(b_hi) * PLH_W'(f_lo);
            m1_pll_reg  <= PLL_W'(b_lo) * PLL_W'(f_lo);
            m1_il_reg   <= m0_il_reg;

            m2_hi_reg   <= (aldp_pkg::HI_W'(m1_phh_reg) << aldp_pkg::BL_W)
                           + aldp_pkg::HI_W'(m1_phl_reg);
            m2_lo_reg   <= (aldp_pkg::LO_W'(m1_plh_reg) << aldp_pkg::BL_W)
                           + aldp_pkg::LO_W'(m1_pll_reg);
            m2_il_reg   <= m1_il_reg;

            // interior cells and cells off the grid give all zeros
            out_il_reg   <= m2_il_reg;
            out_sat_reg  <= m2_il_reg && sat_next;
            out_damp_reg <= !m2_il_reg ? '0 :
                            sat_next   ? '1 : d_next[aldp_pkg::DAMP_W-1:0];
        end
    end

    assign coef.valid     = out_vld_reg;
    assign coef.damping   = out_damp_reg;
    assign coef.in_layer  = out_il_reg;
    assign coef.saturated = out_sat_reg;

    a_interior_zero: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && !coef.in_layer |-> coef.damping == '0 && !coef.saturated)
        else $error("interior beat with nonzero damping");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && coef.saturated |-> coef.damping == '1 && coef.in_layer)
        else $error("saturated beat not clipped");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && !coef.ready |-> !grid.ready)
        else $error("input taken while pipeline stalled");

endmodule

`default_nettype wire
